// ===== rtl/core/word_substitution_hash_lookup_defines.svh =====
// Assertion helpers for the checker file.
`ifndef WORD_SUBSTITUTION_HASH_LOOKUP_DEFINES_SVH
`define WORD_SUBSTITUTION_HASH_LOOKUP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define WSHL_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wshl assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define WSHL_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wshl assertion failed");

`endif

// ===== rtl/core/wshl_pkg.sv =====
package wshl_pkg;

    localparam int ENTRIES       = 16;
    localparam int IDX_W         = 4;
    localparam int MAX_KEY_LEN   = 32;
    localparam int MAX_VALUE_LEN = 32;
    localparam int POS_W         = 5;
    localparam int LEN_W         = 6;
    localparam int CNT_W         = 5;
    localparam int ADDR_W        = IDX_W + POS_W;
    localparam int HASH_W        = 32;

    localparam logic [HASH_W-1:0] HASH_SEED = 32'd5381;

    localparam logic [1:0] OP_TEXT   = 2'd0;
    localparam logic [1:0] OP_KEY    = 2'd1;
    localparam logic [1:0] OP_VALUE  = 2'd2;
    localparam logic [1:0] OP_COMMIT = 2'd3;

    typedef struct packed {
        logic [1:0]       op;
        logic [IDX_W-1:0] entry_index;
        logic [POS_W-1:0] position;
        logic [7:0]       data_byte;
        logic [LEN_W-1:0] key_length;
        logic [LEN_W-1:0] value_length;
        logic             end_of_text;
    } wshl_req_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       text_done;
    } wshl_rsp_t;

    function automatic logic is_word_byte(input logic [7:0] b);
        is_word_byte = (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) ||
                       (b >= 8'h30 && b <= 8'h39) || (b == 8'h5F);
    endfunction

    function automatic logic [HASH_W-1:0] djb2_step(input logic [HASH_W-1:0] h,
                                                    input logic [7:0] b);
        djb2_step = (h << 5) + h + {{(HASH_W-8){1'b0}}, b};
    endfunction

endpackage

// ===== rtl/core/wshl_ram.sv =====
module wshl_ram #(
    parameter int AW = 9,
    parameter int DW = 8
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/word_substitution_hash_lookup.sv =====
// channel | dir | handshake          | payload
// req     | in  | req_valid/req_stall | wshl_req_t (op, index, position, byte, lengths, eot)
// rsp     | out | rsp_valid/rsp_stall | wshl_rsp_t (out_byte, last_of_run, text_done)
// cfg     | in  | cfg_we              | cfg_wdata = entry_count
//
// Table writes (key/value byte) complete in idle; a text byte inside a word passes
// through S_TEXT. A word end scans the entries, compares a matching key byte by
// byte, then emits each byte via a read state and a write state (one registered
// read port per key/value/word memory). A commit hashes the key from key memory.
// Reset clears control and word state only; tables are undefined until written.
// A stalled output holds its byte; the engine waits on it and takes no request.
module word_substitution_hash_lookup (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  wshl_pkg::wshl_req_t req,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output wshl_pkg::wshl_rsp_t rsp,
    input  logic               cfg_we,
    input  logic [4:0]         cfg_wdata
);
    import wshl_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_TEXT     = 4'd1;
    localparam logic [3:0] S_HASH_RD  = 4'd2;
    localparam logic [3:0] S_HASH_ACC = 4'd3;
    localparam logic [3:0] S_SCAN     = 4'd4;
    localparam logic [3:0] S_CMP_RD   = 4'd5;
    localparam logic [3:0] S_CMP_CHK  = 4'd6;
    localparam logic [3:0] S_VAL_RD   = 4'd7;
    localparam logic [3:0] S_VAL_WR   = 4'd8;
    localparam logic [3:0] S_BUF_RD   = 4'd9;
    localparam logic [3:0] S_BUF_WR   = 4'd10;
    localparam logic [3:0] S_BYTE     = 4'd11;
    localparam logic [3:0] S_FIN      = 4'd12;

    logic [3:0]        state_reg, state_next;
    wshl_req_t         cur_reg, cur_next;
    logic              pt_reg, pt_next;
    logic [LEN_W-1:0]  wlen_reg, wlen_next;
    logic [HASH_W-1:0] whash_reg, whash_next;
    logic [IDX_W:0]    ent_reg, ent_next;
    logic [LEN_W-1:0]  cnt_reg, cnt_next;
    logic              tail_reg, tail_next;     // boundary byte follows the run
    logic [HASH_W-1:0] hacc_reg, hacc_next;
    logic [4:0]        count_reg;
    logic              rsp_valid_reg, rsp_valid_next;
    wshl_rsp_t         rsp_reg, rsp_next;

    // per-entry tables, each read at the scan index only
    logic [LEN_W-1:0]  klen_tab [ENTRIES];
    logic [LEN_W-1:0]  vlen_tab [ENTRIES];
    logic [HASH_W-1:0] hash_tab [ENTRIES];
    logic              tab_we;

    logic              accept, out_free, push, push_last;
    logic [7:0]        push_byte;
    logic [IDX_W:0]    limit;
    logic [LEN_W-1:0]  klen_sat, vlen_sat;
    logic [IDX_W-1:0]  ent_idx;

    logic              key_we, val_we, wb_we;
    logic [ADDR_W-1:0] key_raddr, val_raddr;
    logic [7:0]        key_rdata, val_rdata, wb_rdata;

    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign ent_idx   = ent_reg[IDX_W-1:0];
    assign limit     = (count_reg > 5'(ENTRIES)) ? (IDX_W+1)'(ENTRIES) : count_reg;
    assign klen_sat  = (cur_reg.key_length > LEN_W'(MAX_KEY_LEN)) ?
                       LEN_W'(MAX_KEY_LEN) : cur_reg.key_length;
    assign vlen_sat  = (cur_reg.value_length > LEN_W'(MAX_VALUE_LEN)) ?
                       LEN_W'(MAX_VALUE_LEN) : cur_reg.value_length;

    assign key_we    = accept && (req.op == OP_KEY);
    assign val_we    = accept && (req.op == OP_VALUE);
    assign key_raddr = (state_reg == S_HASH_RD) ? {cur_reg.entry_index, cnt_reg[CNT_W-1:0]}
                                                : {ent_idx, cnt_reg[CNT_W-1:0]};
    assign val_raddr = {ent_idx, cnt_reg[CNT_W-1:0]};

    wshl_ram #(.AW(ADDR_W), .DW(8)) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr ({req.entry_index, req.position}),
        .wdata (req.data_byte),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    wshl_ram #(.AW(ADDR_W), .DW(8)) u_val_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr ({req.entry_index, req.position}),
        .wdata (req.data_byte),
        .raddr (val_raddr),
        .rdata (val_rdata)
    );

    wshl_ram #(.AW(CNT_W), .DW(8)) u_word_ram (
        .clk   (clk),
        .we    (wb_we),
        .waddr (wlen_reg[CNT_W-1:0]),
        .wdata (cur_reg.data_byte),
        .raddr (cnt_reg[CNT_W-1:0]),
        .rdata (wb_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        pt_next    = pt_reg;
        wlen_next  = wlen_reg;
        whash_next = whash_reg;
        ent_next   = ent_reg;
        cnt_next   = cnt_reg;
        tail_next  = tail_reg;
        hacc_next  = hacc_reg;
        tab_we     = 1'b0;
        wb_we      = 1'b0;
        push       = 1'b0;
        push_last  = 1'b0;
        push_byte  = cur_reg.data_byte;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cur_next = req;
                    cnt_next = '0;
                    hacc_next = HASH_SEED;
                    if (req.op == OP_TEXT)
                    begin
                        state_next = S_TEXT;
                    end
                    else if (req.op == OP_COMMIT)
                    begin
                        state_next = S_HASH_RD;
                    end
                end
            end
            S_TEXT:
            begin
                ent_next = '0;
                cnt_next = '0;
                tail_next = 1'b1;
                if (is_word_byte(cur_reg.data_byte))
                begin
                    if (pt_reg)
                    begin
                        state_next = S_BYTE;
                    end
                    else if (wlen_reg >= LEN_W'(MAX_KEY_LEN))
                    begin
                        // overlong word: dump buffer, then pass the rest through
                        pt_next = 1'b1;
                        state_next = S_BUF_RD;
                    end
                    else
                    begin
                        wb_we = 1'b1;
                        wlen_next = wlen_reg + 1'b1;
                        whash_next = djb2_step(whash_reg, cur_reg.data_byte);
                        tail_next = 1'b0;
                        state_next = cur_reg.end_of_text ? S_SCAN : S_IDLE;
                    end
                end
                else if (pt_reg)
                begin
                    pt_next = 1'b0;
                    state_next = S_BYTE;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_HASH_RD:
            begin
                if (cnt_reg == klen_sat)
                begin
                    tab_we = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_HASH_ACC;
                end
            end
            S_HASH_ACC:
            begin
                hacc_next = djb2_step(hacc_reg, key_rdata);
                cnt_next = cnt_reg + 1'b1;
                state_next = S_HASH_RD;
            end
            S_SCAN:
            begin
                cnt_next = '0;
                if (wlen_reg == '0)
                begin
                    state_next = tail_reg ? S_BYTE : S_FIN;
                end
                else if (ent_reg >= limit)
                begin
                    state_next = S_BUF_RD;
                end
                else if (hash_tab[ent_idx] == whash_reg && klen_tab[ent_idx] == wlen_reg)
                begin
                    state_next = S_CMP_RD;
                end
                else
                begin
                    ent_next = ent_reg + 1'b1;
                end
            end
            S_CMP_RD:
            begin
                state_next = S_CMP_CHK;
            end
            S_CMP_CHK:
            begin
                if (key_rdata != wb_rdata)
                begin
                    ent_next = ent_reg + 1'b1;
                    state_next = S_SCAN;
                end
                else if (cnt_reg == wlen_reg - 1'b1)
                begin
                    cnt_next = '0;
                    if (vlen_tab[ent_idx] == '0)
                    begin
                        state_next = tail_reg ? S_BYTE : S_FIN;
                    end
                    else
                    begin
                        state_next = S_VAL_RD;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                    state_next = S_CMP_RD;
                end
            end
            S_VAL_RD:
            begin
                state_next = S_VAL_WR;
            end
            S_VAL_WR:
            begin
                if (out_free)
                begin
                    push = 1'b1;
                    push_byte = val_rdata;
                    push_last = !tail_reg && (cnt_reg == vlen_tab[ent_idx] - 1'b1);
                    if (cnt_reg == vlen_tab[ent_idx] - 1'b1)
                    begin
                        state_next = tail_reg ? S_BYTE : S_FIN;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                        state_next = S_VAL_RD;
                    end
                end
            end
            S_BUF_RD:
            begin
                state_next = S_BUF_WR;
            end
            S_BUF_WR:
            begin
                if (out_free)
                begin
                    push = 1'b1;
                    push_byte = wb_rdata;
                    push_last = !tail_reg && (cnt_reg == wlen_reg - 1'b1);
                    if (cnt_reg == wlen_reg - 1'b1)
                    begin
                        state_next = tail_reg ? S_BYTE : S_FIN;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                        state_next = S_BUF_RD;
                    end
                end
            end
            S_BYTE:
            begin
                if (out_free)
                begin
                    push = 1'b1;
                    push_last = 1'b1;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                wlen_next = '0;
                whash_next = HASH_SEED;
                if (cur_reg.end_of_text)
                begin
                    pt_next = 1'b0;
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // word append with end of text ends through the scan and S_FIN
        rsp_next = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        if (push)
        begin
            rsp_valid_next = 1'b1;
            rsp_next.out_byte = push_byte;
            rsp_next.last_of_run = push_last;
            rsp_next.text_done = push_last && cur_reg.end_of_text;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pt_reg        <= 1'b0;
            wlen_reg      <= '0;
            whash_reg     <= HASH_SEED;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pt_reg        <= pt_next;
            wlen_reg      <= wlen_next;
            whash_reg     <= whash_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                count_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        ent_reg  <= ent_next;
        cnt_reg  <= cnt_next;
        tail_reg <= tail_next;
        hacc_reg <= hacc_next;
        rsp_reg  <= rsp_next;
        if (tab_we)
        begin
            klen_tab[cur_reg.entry_index] <= klen_sat;
            vlen_tab[cur_reg.entry_index] <= vlen_sat;
            hash_tab[cur_reg.entry_index] <= hacc_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== rtl/core/wshl_checker.sv =====
`include "word_substitution_hash_lookup_defines.svh"

module wshl_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_stall,
    input wshl_pkg::wshl_req_t req,
    input logic                rsp_valid,
    input logic                rsp_stall,
    input wshl_pkg::wshl_rsp_t rsp
);
    import wshl_pkg::*;

    // a held output byte stays put
    `WSHL_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))
    // end of text only on the closing byte of a run
    `WSHL_ASSERT_IMP(a_done_last, rsp_valid && rsp.text_done, rsp.last_of_run)
    // table requests never produce output
    `WSHL_ASSERT_NXT(a_tbl_quiet,
        req_valid && !req_stall && req.op != OP_TEXT && !rsp_valid, !rsp_valid)

endmodule

bind word_substitution_hash_lookup wshl_checker u_wshl_checker (.*);

// ===== tb/sv/word_substitution_hash_lookup_tb.sv =====
`timescale 1ns / 100ps

module word_substitution_hash_lookup_tb;
    import wshl_pkg::*;

    // Longest quiet spell needed after the last result: a full scan of 16
    // entries with 32-byte key compares, plus a commit hash pass.
    localparam int DRAIN_CYCLES = 1500;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    wshl_req_t req       = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    wshl_rsp_t rsp;
    logic       cfg_we    = 1'b0;
    logic [4:0] cfg_wdata = '0;

    word_substitution_hash_lookup i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Substitution table predictor: own copy of tables, word state and
    // the entry count register.
    // ------------------------------------------------------------------
    logic [7:0]  key_mem [16][32];
    logic [7:0]  val_mem [16][32];
    int          key_len_tbl [16];
    int          val_len_tbl [16];
    logic [31:0] key_hash_tbl [16];
    logic [7:0]  word_buf [32];
    int          held_len   = 0;
    logic [31:0] word_hash  = HASH_SEED;
    bit          passthru   = 1'b0;
    int          live_count = 0;

    // Key and value bytes written at load time, per entry; later writes and
    // commits stay inside these spans so no lookup reads an unwritten byte.
    int          key_ext [16];
    int          val_ext [16];

    logic [7:0] run_bytes[$];          // bytes produced by the current request
    wshl_rsp_t  expected_bytes[$];     // output bytes still to arrive

    wshl_req_t pending_reqs[$];
    int        queued_cnt   = 0;
    int        accepted_cnt = 0;
    int        text_cnt     = 0;
    int        checked_cnt  = 0;
    int        mismatches   = 0;
    bit        no_idle      = 1'b0;
    int        send_gap     = 0;
    int        stall_left   = 0;

    function automatic bit word_char(logic [7:0] b);
        return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") ||
               (b >= "0" && b <= "9") || b == "_";
    endfunction

    function automatic logic [31:0] hash_next(logic [31:0] h, logic [7:0] b);
        return h * 33 + {24'd0, b};
    endfunction

    function automatic void clear_word();
        held_len  = 0;
        word_hash = HASH_SEED;
    endfunction

    // Word end: lowest matching entry wins, otherwise the word goes out as is.
    function automatic void flush_word();
        int  lim;
        bit  same;
        lim = (live_count > 16) ? 16 : live_count;
        if (held_len == 0)
            return;
        for (int e = 0; e < lim; e++)
        begin
            if (key_hash_tbl[e] != word_hash || key_len_tbl[e] != held_len)
                continue;
            same = 1'b1;
            for (int i = 0; i < held_len; i++)
                if (key_mem[e][i] != word_buf[i])
                    same = 1'b0;
            if (!same)
                continue;
            for (int i = 0; i < val_len_tbl[e]; i++)
                run_bytes.push_back(val_mem[e][i]);
            clear_word();
            return;
        end
        for (int i = 0; i < held_len; i++)
            run_bytes.push_back(word_buf[i]);
        clear_word();
    endfunction

    function automatic void predict(wshl_req_t r);
        logic [31:0] h;
        int          kl;
        int          vl;
        wshl_rsp_t   o;
        run_bytes.delete();
        case (r.op)
            OP_KEY:   key_mem[r.entry_index][r.position] = r.data_byte;
            OP_VALUE: val_mem[r.entry_index][r.position] = r.data_byte;
            OP_COMMIT:
            begin
                kl = (r.key_length > 32) ? 32 : r.key_length;
                vl = (r.value_length > 32) ? 32 : r.value_length;
                h  = HASH_SEED;
                for (int i = 0; i < kl; i++)
                    h = hash_next(h, key_mem[r.entry_index][i]);
                key_len_tbl[r.entry_index]  = kl;
                val_len_tbl[r.entry_index]  = vl;
                key_hash_tbl[r.entry_index] = h;
            end
            default:
            begin
                if (word_char(r.data_byte))
                begin
                    if (passthru)
                        run_bytes.push_back(r.data_byte);
                    else if (held_len >= 32)
                    begin
                        // overlong word: dump the buffer, then pass the rest through
                        for (int i = 0; i < held_len; i++)
                            run_bytes.push_back(word_buf[i]);
                        run_bytes.push_back(r.data_byte);
                        clear_word();
                        passthru = 1'b1;
                    end
                    else
                    begin
                        word_buf[held_len] = r.data_byte;
                        held_len++;
                        word_hash = hash_next(word_hash, r.data_byte);
                        if (r.end_of_text)
                            flush_word();
                    end
                end
                else
                begin
                    if (passthru)
                        passthru = 1'b0;
                    else
                        flush_word();
                    run_bytes.push_back(r.data_byte);
                end
                if (r.end_of_text)
                begin
                    clear_word();
                    passthru = 1'b0;
                end
                foreach (run_bytes[i])
                begin
                    o.out_byte    = run_bytes[i];
                    o.last_of_run = (i == run_bytes.size() - 1);
                    o.text_done   = o.last_of_run && r.end_of_text;
                    expected_bytes.push_back(o);
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Idle lengths: mostly back to back, some short gaps, a few long ones.
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Request driver: holds the payload while stalled, then pops the next one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else if (!req_valid || !req_stall)
        begin
            if (req_valid)
            begin
                predict(req);
                accepted_cnt++;
            end
            if (send_gap > 0 && !no_idle)
            begin
                send_gap--;
                req_valid <= 1'b0;
            end
            else if (pending_reqs.size() > 0)
            begin
                req       <= pending_reqs.pop_front();
                req_valid <= 1'b1;
                send_gap  = pick_gap();
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
    end

    // Output monitor plus random back pressure on the output side.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                checked_cnt++;
                if (expected_bytes.size() == 0)
                begin
                    $display("%0t: unexpected output byte=%02h last=%b done=%b", $time,
                             rsp.out_byte, rsp.last_of_run, rsp.text_done);
                    mismatches++;
                end
                else if (rsp !== expected_bytes[0])
                begin
                    $display("%0t: mismatch expected byte=%02h last=%b done=%b,",
                             $time, expected_bytes[0].out_byte,
                             expected_bytes[0].last_of_run, expected_bytes[0].text_done);
                    $display("    actual byte=%02h last=%b done=%b",
                             rsp.out_byte, rsp.last_of_run, rsp.text_done);
                    mismatches++;
                    void'(expected_bytes.pop_front());
                end
                else
                begin
                    void'(expected_bytes.pop_front());
                end
            end
            if (no_idle)
                rsp_stall <= 1'b0;
            else if (stall_left > 0)
                stall_left--;
            else
            begin
                rsp_stall <= ($urandom_range(0, 2) == 0);
                stall_left = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_text(logic [7:0] b, bit eot);
        wshl_req_t r;
        r             = wshl_req_t'($urandom);   // unused fields carry noise
        r.op          = OP_TEXT;
        r.data_byte   = b;
        r.end_of_text = eot;
        pending_reqs.push_back(r);
        queued_cnt++;
        text_cnt++;
    endtask

    task automatic push_table(logic [1:0] op, int idx, int pos, logic [7:0] b,
                              int kl, int vl);
        wshl_req_t r;
        r              = wshl_req_t'($urandom);
        r.op           = op;
        r.entry_index  = IDX_W'(idx);
        r.position     = POS_W'(pos);
        r.data_byte    = b;
        r.key_length   = LEN_W'(kl);
        r.value_length = LEN_W'(vl);
        pending_reqs.push_back(r);
        queued_cnt++;
    endtask

    task automatic push_word(string s, bit eot_last);
        for (int i = 0; i < s.len(); i++)
            push_text(s[i], eot_last && i == s.len() - 1);
    endtask

    function automatic logic [7:0] rand_word_char();
        int k;
        k = $urandom_range(0, 62);
        if (k < 26)
            return 8'("a" + k);
        if (k < 52)
            return 8'("A" + k - 26);
        if (k < 62)
            return 8'("0" + k - 52);
        return "_";
    endfunction

    function automatic logic [7:0] rand_boundary();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (word_char(b));
        return b;
    endfunction

    function automatic string rand_word(int n);
        string s;
        s = "";
        for (int i = 0; i < n; i++)
        begin
            s = {s, " "};
            s.putc(i, rand_word_char());
        end
        return s;
    endfunction

    // Committed key of an entry as the predictor currently holds it.
    function automatic string key_of(int e);
        string s;
        s = "";
        for (int i = 0; i < key_len_tbl[e]; i++)
        begin
            s = {s, " "};
            s.putc(i, key_mem[e][i]);
        end
        return s;
    endfunction

    // Writes the key bytes and the first vl value bytes, then commits.
    task automatic load_entry(int idx, string key, int vl);
        for (int p = 0; p < key.len(); p++)
            push_table(OP_KEY, idx, p, key[p], 0, 0);
        for (int p = 0; p < vl; p++)
            push_table(OP_VALUE, idx, p, 8'($urandom_range(0, 255)), 0, 0);
        push_table(OP_COMMIT, idx, 0, 8'h00, key.len(), vl);
        key_ext[idx] = key.len();
        val_ext[idx] = vl;
    endtask

    // Wait for every request to be taken and answered, then let any
    // result-free work finish before the next register write.
    task automatic wait_idle();
        do
            @(posedge clk);
        while (accepted_cnt != queued_cnt || expected_bytes.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_count(logic [4:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        live_count = v;
    endtask

    task automatic random_text(int n_items);
        int start;
        int kind;
        int e;
        start = text_cnt;
        while (text_cnt - start < n_items)
        begin
            kind = $urandom_range(0, 99);
            e    = $urandom_range(0, 15);
            if (kind < 40)
            begin
                push_word(key_of(e), 1'b0);            // likely table hit
                push_text(rand_boundary(), 1'b0);
            end
            else if (kind < 62)
            begin
                push_word(rand_word($urandom_range(1, 6)), 1'b0);
                push_text(rand_boundary(), 1'b0);
            end
            else if (kind < 72)
            begin
                repeat ($urandom_range(1, 2)) push_text(rand_boundary(), 1'b0);
            end
            else if (kind < 82)
            begin
                // end of text landing on a key, a random word or a boundary
                if ($urandom_range(0, 1))
                    push_word(key_of(e), 1'b1);
                else if ($urandom_range(0, 1))
                    push_word(rand_word($urandom_range(1, 4)), 1'b1);
                else
                    push_text(rand_boundary(), 1'b1);
            end
            else if (kind < 90 || (kind < 95 && val_ext[e] == 0))
                push_table(OP_KEY, e, $urandom_range(0, key_ext[e] - 1),
                           rand_word_char(), 0, 0);
            else if (kind < 95)
                push_table(OP_VALUE, e, $urandom_range(0, val_ext[e] - 1),
                           8'($urandom_range(0, 255)), 0, 0);
            else
                push_table(OP_COMMIT, e, 0, 8'h00, $urandom_range(1, key_ext[e]),
                           $urandom_range(0, val_ext[e]));
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic [4:0] counts [5];
        string      dup_key;
        string      long_key;
        string      empty_key;
        counts = '{5'd0, 5'd7, 5'd31, 5'd1, 5'd16};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Table: duplicate key in entries 2 and 5, a full 32-byte key with a
        // full-length value in 7, an empty replacement in 9.
        dup_key   = rand_word(3);
        long_key  = rand_word(32);
        empty_key = rand_word(4);
        for (int e = 0; e < 16; e++)
        begin
            case (e)
                2, 5:    load_entry(e, dup_key, $urandom_range(1, 3));
                7:       load_entry(e, long_key, 32);
                9:       load_entry(e, empty_key, 0);
                default: load_entry(e, rand_word($urandom_range(1, 3)), $urandom_range(0, 3));
            endcase
        end
        wait_idle();
        write_count(5'd16);

        // Directed: hits, lowest-index win, wide boundaries, longest key,
        // overlong word, empty value, stale hash after a key rewrite, length
        // clamping at commit, end of text.
        push_word(key_of(0), 1'b0);
        push_text(" ", 1'b0);
        push_word(dup_key, 1'b0);
        push_text(",", 1'b0);
        push_word("q_9", 1'b0);
        push_text(8'hFF, 1'b0);
        push_text(8'h00, 1'b0);
        push_text(8'h80, 1'b0);
        push_word(long_key, 1'b0);
        push_text(".", 1'b0);
        push_word({long_key, "Zz"}, 1'b0);
        push_text(" ", 1'b0);
        push_word(empty_key, 1'b0);
        push_text("-", 1'b0);
        push_table(OP_KEY, 0, 0, 8'h7E, 0, 0);
        push_word(key_of(0), 1'b0);
        push_text(" ", 1'b0);
        push_table(OP_COMMIT, 7, 0, 8'h00, 63, 63);   // both lengths clamp
        push_word(empty_key, 1'b1);
        push_word("ab", 1'b1);
        push_text("!", 1'b1);
        wait_idle();

        // Random phases, one entry count each; the middle one runs flat out.
        for (int ph = 0; ph < 5; ph++)
        begin
            write_count(counts[ph]);
            no_idle = (ph == 2);
            random_text(6);
            wait_idle();
        end
        no_idle = 1'b0;

        $display("Covered %0d text requests and %0d output bytes over entry counts",
                 text_cnt, checked_cnt);
        $display("0, 1, 7, 16 and 31, with hits, misses, duplicate keys, overlong words and rewrites.");
        if (mismatches == 0 && expected_bytes.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #10ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
